FILE: rtl/segment_ray_intersection_assert.svh
// assertion macros for the segment/ray intersection block
// expects clk_i and rst_ni in the scope of use
`ifndef SEGMENT_RAY_INTERSECTION_ASSERT_SVH
`define SEGMENT_RAY_INTERSECTION_ASSERT_SVH

// same-cycle implication, off during reset
`define SRI_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define SRI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/sri_pkg.sv
// widths, stage types and helper functions for segment_ray_intersection
// no dependencies
`default_nettype none
package sri_pkg;
  localparam int unsigned CoordBits = 13;
  localparam int unsigned DeltaBits = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DeltaBits;
  localparam int unsigned NumBits   = ProdBits + 1;
  localparam int unsigned TopBits   = NumBits + DeltaBits + 1;
  localparam int unsigned QuotBits  = 17;
  localparam int unsigned CmpBits   = NumBits + QuotBits;
  localparam int unsigned OutBits   = 16;
  localparam int unsigned NumStages = QuotBits + 7;

  localparam logic [QuotBits-1:0] PosLimit = QuotBits'(32767);
  localparam logic [QuotBits-1:0] NegLimit = QuotBits'(32768);

  typedef struct packed {
    logic [TopBits-1:0]  rem;
    logic [QuotBits-1:0] quot;
    logic                neg;
    logic                ovf;
  } lane_t;

  typedef struct packed {
    lane_t              x;
    lane_t              y;
    logic [NumBits-1:0] dmag;
    logic               hit;
  } div_stage_t;

  // one restoring division step for quotient bit pos
  function automatic lane_t div_step(lane_t l, logic [NumBits-1:0] dm,
                                     logic [4:0] pos);
    logic [CmpBits-1:0] sh;
    lane_t r;
    sh = CmpBits'(dm) << pos;
    r  = l;
    if (CmpBits'(l.rem) >= sh) begin
      r.rem       = l.rem - TopBits'(sh);
      r.quot[pos] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [OutBits-1:0] sat_out(lane_t l);
    logic [QuotBits:0] negq;
    logic signed [OutBits-1:0] r;
    negq = (QuotBits+1)'(0) - {1'b0, l.quot};
    if (!l.neg) begin
      if (l.ovf || l.quot > PosLimit) r = OutBits'(PosLimit);
      else r = OutBits'(l.quot);
    end else begin
      if (l.ovf || l.quot > NegLimit) r = OutBits'(NegLimit);
      else r = OutBits'(negq);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/segment_ray_intersection.sv
// segment_ray_intersection: pipelined crossing test and crossing point
// depends on sri_pkg and segment_ray_intersection_assert.svh
`default_nettype none
// Takes one pair of lines per cycle while in_stall_o is low and returns one
// beat per pair in the same order. It has five arithmetic stages (deltas, cross
// products, numerators, scaling multiplies, magnitudes), a range check, a
// 17-stage restoring divider giving one quotient bit per stage, and the
// output register. Each stage holds its beat only while the one after it is
// full and held, so bubbles are squeezed out and a stalled output still lets
// new beats fill the pipe. Crossing coordinates are truncated toward zero and
// saturated to 16 bits; a miss returns zero coordinates.
module segment_ray_intersection (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic signed [sri_pkg::CoordBits-1:0] first_start_x_i,
  input  wire logic signed [sri_pkg::CoordBits-1:0] first_start_y_i,
  input  wire logic signed [sri_pkg::CoordBits-1:0] first_end_x_i,
  input  wire logic signed [sri_pkg::CoordBits-1:0] first_end_y_i,
  input  wire logic                                first_is_ray_i,
  input  wire logic signed [sri_pkg::CoordBits-1:0] second_start_x_i,
  input  wire logic signed [sri_pkg::CoordBits-1:0] second_start_y_i,
  input  wire logic signed [sri_pkg::CoordBits-1:0] second_end_x_i,
  input  wire logic signed [sri_pkg::CoordBits-1:0] second_end_y_i,
  input  wire logic                                second_is_ray_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic                                hit_o,
  output      logic signed [sri_pkg::OutBits-1:0]   cross_x_o,
  output      logic signed [sri_pkg::OutBits-1:0]   cross_y_o
);
  import sri_pkg::*;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  assign en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o = !en[0];

  // stage 0: deltas
  logic signed [CoordBits-1:0] ax0_q, ay0_q;
  logic signed [DeltaBits-1:0] d1x_q, d1y_q, d2x_q, d2y_q, wx_q, wy_q;
  logic ray1_0_q, ray2_0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ax0_q    <= first_start_x_i;
      ay0_q    <= first_start_y_i;
      d1x_q    <= DeltaBits'(first_start_x_i) - DeltaBits'(first_end_x_i);
      d1y_q    <= DeltaBits'(first_start_y_i) - DeltaBits'(first_end_y_i);
      d2x_q    <= DeltaBits'(second_start_x_i) - DeltaBits'(second_end_x_i);
      d2y_q    <= DeltaBits'(second_start_y_i) - DeltaBits'(second_end_y_i);
      wx_q     <= DeltaBits'(first_start_x_i) - DeltaBits'(second_start_x_i);
      wy_q     <= DeltaBits'(first_start_y_i) - DeltaBits'(second_start_y_i);
      ray1_0_q <= first_is_ray_i;
      ray2_0_q <= second_is_ray_i;
    end
  end

  // stage 1: cross products
  logic signed [ProdBits-1:0] p_dd0_q, p_dd1_q, p_n10_q, p_n11_q, p_n20_q, p_n21_q;
  logic signed [CoordBits-1:0] ax1_q, ay1_q;
  logic signed [DeltaBits-1:0] d1x1_q, d1y1_q;
  logic ray1_1_q, ray2_1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_dd0_q  <= d1x_q * d2y_q;
      p_dd1_q  <= d1y_q * d2x_q;
      p_n10_q  <= wx_q * d2y_q;
      p_n11_q  <= wy_q * d2x_q;
      p_n20_q  <= wx_q * d1y_q;
      p_n21_q  <= wy_q * d1x_q;
      ax1_q    <= ax0_q;
      ay1_q    <= ay0_q;
      d1x1_q   <= d1x_q;
      d1y1_q   <= d1y_q;
      ray1_1_q <= ray1_0_q;
      ray2_1_q <= ray2_0_q;
    end
  end

  // stage 2: denominator and numerators
  logic signed [NumBits-1:0] denom_q, num1_q, num2_q;
  logic signed [CoordBits-1:0] ax2_q, ay2_q;
  logic signed [DeltaBits-1:0] d1x2_q, d1y2_q;
  logic ray1_2_q, ray2_2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      denom_q  <= NumBits'(p_dd0_q) - NumBits'(p_dd1_q);
      num1_q   <= NumBits'(p_n10_q) - NumBits'(p_n11_q);
      num2_q   <= NumBits'(p_n20_q) - NumBits'(p_n21_q);
      ax2_q    <= ax1_q;
      ay2_q    <= ay1_q;
      d1x2_q   <= d1x1_q;
      d1y2_q   <= d1y1_q;
      ray1_2_q <= ray1_1_q;
      ray2_2_q <= ray2_1_q;
    end
  end

  // stage 3: hit decision and scaling products
  logic hit_d;
  always_comb begin
    if (denom_q == '0) begin
      hit_d = 1'b0;
    end else if (!denom_q[NumBits-1]) begin
      hit_d = !(num1_q < 0 || (num1_q > denom_q && !ray1_2_q)) &&
              !(num2_q < 0 || (num2_q > denom_q && !ray2_2_q));
    end else begin
      hit_d = !(num1_q > 0 || (num1_q < denom_q && !ray1_2_q)) &&
              !(num2_q > 0 || (num2_q < denom_q && !ray2_2_q));
    end
  end

  logic signed [CoordBits+NumBits-1:0] pax_q, pay_q;
  logic signed [NumBits+DeltaBits-1:0] pnx_q, pny_q;
  logic signed [NumBits-1:0] denom3_q;
  logic hit3_q;

  // delta of the first line is the negated d1
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      pax_q    <= ax2_q * denom_q;
      pay_q    <= ay2_q * denom_q;
      pnx_q    <= -(num1_q * d1x2_q);
      pny_q    <= -(num1_q * d1y2_q);
      denom3_q <= denom_q;
      hit3_q   <= hit_d;
    end
  end

  // stage 4: sums and magnitudes
  logic signed [TopBits-1:0] topx, topy;
  assign topx = TopBits'(pax_q) + TopBits'(pnx_q);
  assign topy = TopBits'(pay_q) + TopBits'(pny_q);

  logic [TopBits-1:0] absx_q, absy_q;
  logic [NumBits-1:0] dmag4_q;
  logic negx4_q, negy4_q, hit4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      absx_q  <= topx[TopBits-1] ? TopBits'(-topx) : TopBits'(topx);
      absy_q  <= topy[TopBits-1] ? TopBits'(-topy) : TopBits'(topy);
      dmag4_q <= denom3_q[NumBits-1] ? NumBits'(-denom3_q) : NumBits'(denom3_q);
      negx4_q <= topx[TopBits-1] ^ denom3_q[NumBits-1];
      negy4_q <= topy[TopBits-1] ^ denom3_q[NumBits-1];
      hit4_q  <= hit3_q;
    end
  end

  // stage 5: quotient range check, divider entry
  div_stage_t dv_q [QuotBits+1];
  logic [CmpBits-1:0] dlim;
  assign dlim = CmpBits'(dmag4_q) << QuotBits;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      dv_q[0].x.rem  <= absx_q;
      dv_q[0].x.quot <= '0;
      dv_q[0].x.neg  <= negx4_q;
      dv_q[0].x.ovf  <= CmpBits'(absx_q) >= dlim;
      dv_q[0].y.rem  <= absy_q;
      dv_q[0].y.quot <= '0;
      dv_q[0].y.neg  <= negy4_q;
      dv_q[0].y.ovf  <= CmpBits'(absy_q) >= dlim;
      dv_q[0].dmag   <= dmag4_q;
      dv_q[0].hit    <= hit4_q;
    end
  end

  // divider: one quotient bit per stage, msb first
  for (genvar j = 0; j < QuotBits; j++) begin : g_div
    localparam logic [4:0] Pos = 5'(QuotBits - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en[6+j]) begin
        dv_q[j+1].x    <= div_step(dv_q[j].x, dv_q[j].dmag, Pos);
        dv_q[j+1].y    <= div_step(dv_q[j].y, dv_q[j].dmag, Pos);
        dv_q[j+1].dmag <= dv_q[j].dmag;
        dv_q[j+1].hit  <= dv_q[j].hit;
      end
    end
  end

  // output register
  logic hit_q;
  logic signed [OutBits-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      hit_q <= dv_q[QuotBits].hit;
      cx_q  <= dv_q[QuotBits].hit ? sat_out(dv_q[QuotBits].x) : '0;
      cy_q  <= dv_q[QuotBits].hit ? sat_out(dv_q[QuotBits].y) : '0;
    end
  end

  assign out_valid_o = v_q[NumStages-1];
  assign hit_o       = hit_q;
  assign cross_x_o   = cx_q;
  assign cross_y_o   = cy_q;

`include "segment_ray_intersection_assert.svh"

  `SRI_ASSERT_IMPLY(a_miss_zero, out_valid_o && !hit_o, cross_x_o == '0 && cross_y_o == '0)
  `SRI_ASSERT_IMPLY(a_stall_full, in_stall_o, out_valid_o && out_stall_i && (&v_q))
  `SRI_ASSERT_NEXT(a_out_moves, out_valid_o && !out_stall_i && !v_q[NumStages-2], !out_valid_o)

endmodule
`default_nettype wire
